// ----- rtl/cc_pkg.sv -----
// ----------------------------------------------------------------------------
// Code completeness scanner package
// Shared types, character codes and default sizes of the scanner.
// ----------------------------------------------------------------------------
package cc_pkg;

  localparam int MAX_TAG_DEF    = 64;
  localparam int DEPTH_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_OPEN = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PCT_TAGS   = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    MODE_BODY      = 4'd0,
    MODE_SQ        = 4'd1,
    MODE_DQ        = 4'd2,
    MODE_SQ_ESC    = 4'd3,
    MODE_DQ_ESC    = 4'd4,
    MODE_LINE_CMT  = 4'd5,
    MODE_BLOCK_CMT = 4'd6,
    MODE_DOC_OPEN  = 4'd7,
    MODE_DOC_BODY  = 4'd8,
    MODE_OUTSIDE   = 4'd9
  } scan_mode_e;

  typedef enum logic [2:0] {
    PROMPT_NORMAL  = 3'd0,
    PROMPT_PAREN   = 3'd1,
    PROMPT_CURLY   = 3'd2,
    PROMPT_SQUOTE  = 3'd3,
    PROMPT_DQUOTE  = 3'd4,
    PROMPT_COMMENT = 3'd5,
    PROMPT_HEREDOC = 3'd6,
    PROMPT_OUTSIDE = 3'd7
  } prompt_kind_e;

  // One history entry: a byte and whether it exists.
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
  } hist_ent_t;

  typedef struct packed {
    logic       clear;
    logic [1:0] shift;
  } hist_ctrl_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       rshift;
    logic [7:0] wbyte;
    logic [7:0] rbyte;
  } tag_ctrl_t;

  typedef struct packed {
    logic fail_a;
    logic term_a;
    logic fail_b;
    logic term_b;
  } tag_cmp_t;

endpackage

// ----- rtl/cc_if.sv -----
// ----------------------------------------------------------------------------
// Scanner channel interfaces
// Valid/ready channels for code bytes in and scan results out.
// ----------------------------------------------------------------------------
interface cc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface cc_res_if;
  logic       valid;
  logic       ready;
  logic       complete;
  logic [2:0] prompt_kind;

  modport source (output valid, output complete, output prompt_kind, input ready);
  modport sink   (input valid, input complete, input prompt_kind, output ready);
endinterface

// ----- rtl/cc_hist_cell.sv -----
// ----------------------------------------------------------------------------
// History cell
// One entry of the recent-byte row; moves zero to three places per cycle.
// ----------------------------------------------------------------------------
module cc_hist_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cc_pkg::hist_ctrl_t ctrl_i,
  input  cc_pkg::hist_ent_t  p1_i,
  input  cc_pkg::hist_ent_t  p2_i,
  input  cc_pkg::hist_ent_t  p3_i,
  output cc_pkg::hist_ent_t  ent_o
);
  import cc_pkg::*;

  hist_ent_t  ent_d;
  logic [7:0] data_q;
  logic       vld_q;

  always_comb begin
    unique case (ctrl_i.shift)
      2'd0: ent_d = '{data: data_q, vld: vld_q};
      2'd1: ent_d = p1_i;
      2'd2: ent_d = p2_i;
      2'd3: ent_d = p3_i;
      default: ent_d = '{data: data_q, vld: vld_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ent_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= ent_d.data;
  end

  assign ent_o = '{data: data_q, vld: vld_q};

endmodule

// ----- rtl/cc_tag_cell.sv -----
// ----------------------------------------------------------------------------
// Tag cell
// Holds one right-aligned heredoc tag byte and one queued tag byte, and
// compares the tag byte against its two history neighbours.
// ----------------------------------------------------------------------------
module cc_tag_cell (
  input  logic               clk_i,
  input  cc_pkg::tag_ctrl_t  ctrl_i,
  input  logic               wr_sel_i,
  input  logic               active_i,
  input  logic [7:0]         q_next_i,
  input  logic [7:0]         r_prev_i,
  input  cc_pkg::hist_ent_t  h0_i,
  input  cc_pkg::hist_ent_t  h1_i,
  output logic [7:0]         q_o,
  output logic [7:0]         r_o,
  output cc_pkg::tag_cmp_t   cmp_o
);
  import cc_pkg::*;

  logic [7:0] q_d, q_q, r_d, r_q;
  logic       ok_a, ok_b, nul;

  always_comb begin
    q_d = q_q;
    if (ctrl_i.pop) begin
      q_d = wr_sel_i ? ctrl_i.wbyte : q_next_i;
    end else if (wr_sel_i) begin
      q_d = ctrl_i.wbyte;
    end
    r_d = ctrl_i.rshift ? r_prev_i : r_q;
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign ok_a = h0_i.vld && (h0_i.data == r_q);
  assign ok_b = h1_i.vld && (h1_i.data == r_q);
  assign nul  = (r_q == CH_NUL);

  assign cmp_o.fail_a = active_i && !ok_a;
  assign cmp_o.term_a = active_i && ok_a && nul;
  assign cmp_o.fail_b = active_i && !ok_b;
  assign cmp_o.term_b = active_i && ok_b && nul;

  assign q_o = q_q;
  assign r_o = r_q;

endmodule

// ----- rtl/code_completeness_scanner.sv -----
// ----------------------------------------------------------------------------
// Code completeness scanner
// Scans a script buffer byte by byte and tells, at its last byte, whether it
// ends at a complete statement and which prompt class fits.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                        Accepted when
//   req_i     in         code_byte[7:0], last_byte      valid && ready
//   res_o     out        complete, prompt_kind[2:0]     valid && ready
//   cfg       in         cfg_idx_i, cfg_data_i          cfg_we_i
//
// A byte that is not the last is taken in every cycle, with no gap between.
// After the last byte of a buffer the scanner drains the bytes left in the
// lookahead window, as one decision unit works through them; an opener drops
// the bytes it swallows in the same cycle. The request port is held off
// during the drain; while a result waits in the output register only the
// next drain stalls. Reset clears the control state and valid flags; window,
// history and tag bytes and the result payload are not reset.
module code_completeness_scanner #(
  parameter int MAX_TAG    = cc_pkg::MAX_TAG_DEF,
  parameter int DEPTH_BITS = cc_pkg::DEPTH_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cc_req_if.sink                     req_i,
  cc_res_if.source                   res_o,
  input  logic                       cfg_we_i,
  input  logic [cc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic                       cfg_data_i
);
  import cc_pkg::*;

  // History holds the tag plus a leading newline and an optional ';'.
  localparam int HIST  = MAX_TAG + 2;
  localparam int LenW  = $clog2(MAX_TAG + 1);
  localparam int FillW = $clog2(MAX_TAG + 2);

  // Configuration.
  logic short_q, asp_q;

  // Scan state.
  scan_mode_e            mode_q, mode_d, dec_mode;
  logic                  end_ok_q, end_ok_d, dec_end_ok;
  logic                  saved_q, saved_d, dec_saved;
  logic [DEPTH_BITS-1:0] curly_q, curly_d, dec_curly;
  logic [DEPTH_BITS-1:0] paren_q, paren_d, dec_paren;
  logic [LenW-1:0]       len_q, len_d, dec_len;
  logic [FillW-1:0]      fill_q, fill_d, dec_fill;
  logic                  ovf_q, ovf_d, dec_ovf;

  // Lookahead window and drain control.
  logic [7:0] win_q [3];
  logic [7:0] win_d [3];
  logic [1:0] wcnt_q, wcnt_d;
  logic       flush_q, flush_d;

  // Result register.
  logic       out_vld_q, out_vld_d;
  logic       out_cmp_q, out_cmp_d;
  logic [2:0] out_kind_q, out_kind_d;

  logic       req_fire, out_free, adv, finish;
  logic [7:0] wnew [3];
  logic [7:0] w    [3];
  logic [1:0] nnew, n_sel, navail, consume, drop, rem;
  logic [7:0] c0, c1, c2;

  // History row.
  hist_ent_t  hist [HIST];
  hist_ent_t  ext  [HIST+3];
  hist_ctrl_t hctrl;

  // Tag row.
  tag_ctrl_t        tctrl;
  logic [7:0]       tq   [MAX_TAG];
  logic [7:0]       tr   [MAX_TAG];
  tag_cmp_t         tcmp [MAX_TAG];
  logic [LenW-1:0]  qcnt, qwidx;
  logic [FillW-1:0] fill_cap;

  logic b1_star, b1_lt, b1_h, b1_semi, b2_p, b3_q, b4_lt;
  logic nl_a, nl_b, match_a, match_b;

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || res_o.ready;
  assign req_i.ready = !flush_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= 1'b0;
      asp_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_OPEN: short_q <= cfg_data_i;
        CFG_PCT_TAGS:   asp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Window assembly: pending bytes followed by the incoming byte.
  // --------------------------------------------------------------------------
  always_comb begin
    wnew[0] = req_i.code_byte;
    wnew[1] = win_q[1];
    wnew[2] = req_i.code_byte;
    unique case (wcnt_q)
      2'd1: begin
        wnew[0] = win_q[0];
        wnew[1] = req_i.code_byte;
      end
      2'd2: begin
        wnew[0] = win_q[0];
        wnew[1] = win_q[1];
      end
      default: ;
    endcase
  end

  assign nnew   = wcnt_q + 2'd1;
  assign n_sel  = flush_q ? wcnt_q : nnew;
  assign navail = n_sel - 2'd1;
  assign w[0]   = flush_q ? win_q[0] : wnew[0];
  assign w[1]   = flush_q ? win_q[1] : wnew[1];
  assign w[2]   = flush_q ? win_q[2] : wnew[2];
  assign c0 = w[0];
  assign c1 = w[1];
  assign c2 = w[2];

  // A decision is made once three bytes are in hand, or on every drain cycle
  // while the result register has room.
  assign adv = flush_q ? out_free : (req_fire && !req_i.last_byte && (nnew == 2'd3));

  // --------------------------------------------------------------------------
  // Fixed look-back taps
  // --------------------------------------------------------------------------
  assign b1_star = hist[0].vld && (hist[0].data == CH_STAR);
  assign b1_lt   = hist[0].vld && (hist[0].data == CH_LT);
  assign b1_h    = hist[0].vld && (hist[0].data == CH_H);
  assign b1_semi = hist[0].vld && (hist[0].data == CH_SEMI);
  assign b2_p    = hist[1].vld && (hist[1].data == CH_P);
  assign b3_q    = hist[2].vld && (hist[2].data == CH_QUEST);
  assign b4_lt   = hist[3].vld && (hist[3].data == CH_LT);

  // Newline just before the tag, for the plain and the ';'-terminated end.
  always_comb begin
    nl_a = 1'b0;
    nl_b = 1'b0;
    for (int i = 0; i < HIST; i++) begin
      if (hist[i].vld && (hist[i].data == CH_LF)) begin
        if (i == int'(len_q))       nl_a = 1'b1;
        if (i == int'(len_q) + 1)   nl_b = 1'b1;
      end
    end
  end

  // A tag matches unless some mismatch comes before the first matching
  // zero byte; tag order runs from the high cell down to cell zero.
  always_comb begin
    logic term_above_a, term_above_b;
    term_above_a = 1'b0;
    term_above_b = 1'b0;
    match_a = 1'b1;
    match_b = 1'b1;
    for (int m = MAX_TAG - 1; m >= 0; m--) begin
      if (tcmp[m].fail_a && !term_above_a) match_a = 1'b0;
      if (tcmp[m].fail_b && !term_above_b) match_b = 1'b0;
      term_above_a = term_above_a || tcmp[m].term_a;
      term_above_b = term_above_b || tcmp[m].term_b;
    end
  end

  // Queue of tag bytes not yet moved into the aligned tag row.
  assign fill_cap = (fill_q > FillW'(MAX_TAG)) ? FillW'(MAX_TAG) : fill_q;
  assign qcnt     = LenW'(fill_cap - FillW'(len_q));
  assign qwidx    = tctrl.pop ? (qcnt - LenW'(1)) : qcnt;

  // --------------------------------------------------------------------------
  // Decision unit: the oldest window byte against the current scan state.
  // --------------------------------------------------------------------------
  always_comb begin
    dec_mode   = mode_q;
    dec_end_ok = end_ok_q;
    dec_saved  = saved_q;
    dec_curly  = curly_q;
    dec_paren  = paren_q;
    dec_len    = len_q;
    dec_fill   = fill_q;
    dec_ovf    = ovf_q;
    consume    = 2'd0;
    tctrl      = '0;
    tctrl.wbyte = c0;
    tctrl.rbyte = c0;

    unique case (mode_q)
      MODE_SQ: begin
        if (c0 == CH_BSLASH)      dec_mode = MODE_SQ_ESC;
        else if (c0 == CH_SQUOTE) dec_mode = MODE_BODY;
      end
      MODE_SQ_ESC: dec_mode = MODE_SQ;
      MODE_DQ: begin
        if (c0 == CH_BSLASH)      dec_mode = MODE_DQ_ESC;
        else if (c0 == CH_DQUOTE) dec_mode = MODE_BODY;
      end
      MODE_DQ_ESC: dec_mode = MODE_DQ;
      MODE_LINE_CMT: begin
        if (c0 == CH_LF) dec_mode = MODE_BODY;
      end
      MODE_BLOCK_CMT: begin
        if (c0 == CH_SLASH && b1_star) begin
          dec_mode   = MODE_BODY;
          dec_end_ok = saved_q;
        end
      end
      MODE_DOC_OPEN: begin
        if (c0 == CH_CR || c0 == CH_LF) begin
          dec_mode = MODE_DOC_BODY;
        end else if (c0 == CH_SPACE || c0 == CH_TAB) begin
          // Blanks inside the tag are stored but not counted.
          if (len_q != '0) begin
            tctrl.push = (fill_q < FillW'(MAX_TAG));
            if (fill_q <= FillW'(MAX_TAG)) dec_fill = fill_q + FillW'(1);
          end
        end else if (len_q == '0) begin
          tctrl.rshift = 1'b1;
          dec_fill     = FillW'(1);
          dec_len      = LenW'(1);
        end else if (len_q < LenW'(MAX_TAG)) begin
          dec_len      = len_q + LenW'(1);
          tctrl.rshift = 1'b1;
          if (fill_q <= FillW'(MAX_TAG)) dec_fill = fill_q + FillW'(1);
          if (qcnt != '0) begin
            tctrl.pop   = 1'b1;
            tctrl.push  = (fill_q < FillW'(MAX_TAG));
            tctrl.rbyte = tq[0];
          end
        end else begin
          dec_ovf = 1'b1;
          if (fill_q <= FillW'(MAX_TAG)) dec_fill = fill_q + FillW'(1);
        end
      end
      MODE_DOC_BODY: begin
        if (!ovf_q && c0 == CH_LF) begin
          if (nl_a && match_a) begin
            dec_mode = MODE_BODY;
          end else if (nl_b && match_b && b1_semi) begin
            dec_mode   = MODE_BODY;
            dec_end_ok = 1'b1;
          end
        end
      end
      MODE_OUTSIDE: begin
        if ((short_q && c0 == CH_QUEST && b1_lt) ||
            (asp_q && c0 == CH_PCT && b1_lt) ||
            (c0 == CH_P && b4_lt && b3_q && b2_p && b1_h)) begin
          dec_mode = MODE_BODY;
        end
      end
      default: begin
        // Body mode, and any code that means nothing.
        dec_mode = MODE_BODY;
        unique case (c0)
          CH_LCURLY: begin
            if (curly_q != '1) dec_curly = curly_q + DEPTH_BITS'(1);
            dec_end_ok = 1'b0;
          end
          CH_RCURLY: begin
            if (curly_q != '0) dec_curly = curly_q - DEPTH_BITS'(1);
            dec_end_ok = (dec_curly == '0);
          end
          CH_LPAREN: begin
            if (paren_q != '1) dec_paren = paren_q + DEPTH_BITS'(1);
            dec_end_ok = 1'b0;
          end
          CH_RPAREN: begin
            if (paren_q != '0) dec_paren = paren_q - DEPTH_BITS'(1);
            dec_end_ok = 1'b0;
          end
          CH_SEMI: dec_end_ok = (paren_q == '0) && (curly_q == '0);
          CH_SPACE, CH_CR, CH_LF, CH_TAB: ;
          CH_SQUOTE: dec_mode = MODE_SQ;
          CH_DQUOTE: dec_mode = MODE_DQ;
          CH_HASH:   dec_mode = MODE_LINE_CMT;
          CH_SLASH: begin
            if (navail >= 2'd1 && c1 == CH_SLASH) begin
              dec_mode = MODE_LINE_CMT;
              consume  = 2'd1;
            end else if (navail >= 2'd1 && c1 == CH_STAR) begin
              dec_saved  = end_ok_q;
              dec_end_ok = 1'b0;
              dec_mode   = MODE_BLOCK_CMT;
              consume    = 2'd1;
            end else begin
              dec_end_ok = 1'b0;
            end
          end
          CH_PCT, CH_QUEST: begin
            if (c0 == CH_PCT && !asp_q) begin
              dec_end_ok = 1'b0;
            end else if (navail >= 2'd1 && c1 == CH_GT) begin
              dec_mode = MODE_OUTSIDE;
              consume  = 2'd1;
            end else begin
              dec_end_ok = 1'b0;
            end
          end
          CH_LT: begin
            dec_end_ok = 1'b0;
            if (navail == 2'd2 && c1 == CH_LT && c2 == CH_LT) begin
              dec_mode = MODE_DOC_OPEN;
              dec_len  = '0;
              dec_fill = '0;
              dec_ovf  = 1'b0;
              consume  = 2'd2;
            end
          end
          default: dec_end_ok = 1'b0;
        endcase
      end
    endcase

    if (!adv) begin
      tctrl.push   = 1'b0;
      tctrl.pop    = 1'b0;
      tctrl.rshift = 1'b0;
    end
  end

  // Bytes dropped from the window: the decided one plus what it consumed.
  assign drop   = ((2'd1 + consume) > n_sel) ? n_sel : (2'd1 + consume);
  assign rem    = n_sel - drop;
  assign finish = flush_q && out_free && (rem == 2'd0);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    mode_d   = mode_q;
    end_ok_d = end_ok_q;
    saved_d  = saved_q;
    curly_d  = curly_q;
    paren_d  = paren_q;
    len_d    = len_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    win_d    = win_q;
    wcnt_d   = wcnt_q;
    flush_d  = flush_q;

    out_vld_d  = out_vld_q && !res_o.ready;
    out_cmp_d  = out_cmp_q;
    out_kind_d = out_kind_q;

    if (adv) begin
      mode_d   = dec_mode;
      end_ok_d = dec_end_ok;
      saved_d  = dec_saved;
      curly_d  = dec_curly;
      paren_d  = dec_paren;
      len_d    = dec_len;
      fill_d   = dec_fill;
      ovf_d    = dec_ovf;
      wcnt_d   = rem;
      for (int j = 0; j < 3; j++) begin
        if (j + int'(drop) < 3) win_d[j] = w[j + int'(drop)];
      end
    end else if (req_fire) begin
      win_d   = wnew;
      wcnt_d  = nnew;
      flush_d = req_i.last_byte;
    end

    if (finish) begin
      out_vld_d = 1'b1;
      out_cmp_d = dec_end_ok && (dec_curly == '0);
      unique case (dec_mode)
        MODE_SQ, MODE_SQ_ESC: out_kind_d = PROMPT_SQUOTE;
        MODE_DQ, MODE_DQ_ESC: out_kind_d = PROMPT_DQUOTE;
        MODE_BLOCK_CMT:       out_kind_d = PROMPT_COMMENT;
        MODE_DOC_BODY:        out_kind_d = PROMPT_HEREDOC;
        MODE_OUTSIDE:         out_kind_d = PROMPT_OUTSIDE;
        default: begin
          if (dec_paren != '0)      out_kind_d = PROMPT_PAREN;
          else if (dec_curly != '0) out_kind_d = PROMPT_CURLY;
          else                      out_kind_d = PROMPT_NORMAL;
        end
      endcase
      // The scan starts over for the next buffer.
      mode_d   = MODE_BODY;
      end_ok_d = 1'b1;
      saved_d  = 1'b0;
      curly_d  = '0;
      paren_d  = '0;
      len_d    = '0;
      fill_d   = '0;
      ovf_d    = 1'b0;
      wcnt_d   = 2'd0;
      flush_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_BODY;
      end_ok_q  <= 1'b1;
      saved_q   <= 1'b0;
      curly_q   <= '0;
      paren_q   <= '0;
      len_q     <= '0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      wcnt_q    <= 2'd0;
      flush_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      end_ok_q  <= end_ok_d;
      saved_q   <= saved_d;
      curly_q   <= curly_d;
      paren_q   <= paren_d;
      len_q     <= len_d;
      fill_q    <= fill_d;
      ovf_q     <= ovf_d;
      wcnt_q    <= wcnt_d;
      flush_q   <= flush_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    out_cmp_q  <= out_cmp_d;
    out_kind_q <= out_kind_d;
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.complete    = out_cmp_q;
  assign res_o.prompt_kind = out_kind_q;

  // --------------------------------------------------------------------------
  // History row: dropped bytes enter at cell zero, newest first. The oldest
  // dropped byte always sits in ext[2], so it lands deepest in the row.
  // --------------------------------------------------------------------------
  assign hctrl.clear = finish;
  assign hctrl.shift = adv ? drop : 2'd0;

  always_comb begin
    ext[0] = '0;
    ext[1] = '0;
    ext[2] = '0;
    unique case (drop)
      2'd1: ext[2] = '{data: w[0], vld: 1'b1};
      2'd2: begin
        ext[2] = '{data: w[0], vld: 1'b1};
        ext[1] = '{data: w[1], vld: 1'b1};
      end
      2'd3: begin
        ext[2] = '{data: w[0], vld: 1'b1};
        ext[1] = '{data: w[1], vld: 1'b1};
        ext[0] = '{data: w[2], vld: 1'b1};
      end
      default: ;
    endcase
    for (int i = 0; i < HIST; i++) begin
      ext[i+3] = hist[i];
    end
  end

  for (genvar i = 0; i < HIST; i++) begin : g_hist
    cc_hist_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (hctrl),
      .p1_i   (ext[i+2]),
      .p2_i   (ext[i+1]),
      .p3_i   (ext[i]),
      .ent_o  (hist[i])
    );
  end

  // --------------------------------------------------------------------------
  // Tag row: cell m holds tag byte (len - 1 - m), so each cell compares
  // against history cells m and m + 1 at fixed places.
  // --------------------------------------------------------------------------
  for (genvar m = 0; m < MAX_TAG; m++) begin : g_tag
    logic [7:0] q_next, r_prev;
    if (m == MAX_TAG - 1) begin : g_top
      assign q_next = '0;
    end else begin : g_mid
      assign q_next = tq[m+1];
    end
    if (m == 0) begin : g_first
      assign r_prev = tctrl.rbyte;
    end else begin : g_rest
      assign r_prev = tr[m-1];
    end

    cc_tag_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (tctrl),
      .wr_sel_i (tctrl.push && (m == int'(qwidx))),
      .active_i (m < int'(len_q)),
      .q_next_i (q_next),
      .r_prev_i (r_prev),
      .h0_i     (hist[m]),
      .h1_i     (hist[m+1]),
      .q_o      (tq[m]),
      .r_o      (tr[m]),
      .cmp_o    (tcmp[m])
    );
  end

endmodule

// ----- rtl/cc_checker.sv -----
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the scanner's channels and flags behaviour it must never show.
// ----------------------------------------------------------------------------
module cc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_last,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_complete,
  input logic [2:0] res_kind
);
  import cc_pkg::*;

  // A held result keeps its value until it is taken.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_complete) && $stable(res_kind))
    else $error("result changed while stalled");

  // The last byte of a buffer starts the drain, which holds off requests.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_last |=> !req_ready)
    else $error("request taken right after a last byte");

  // A fresh result only appears at the end of a drain.
  a_res_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(!req_ready))
    else $error("result without a drain");

  // An open curly block can never be complete.
  a_curly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_complete |-> res_kind != PROMPT_CURLY)
    else $error("complete reported inside a curly block");

endmodule

bind code_completeness_scanner cc_checker u_cc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid    (req_i.valid),
  .req_ready    (req_i.ready),
  .req_last     (req_i.last_byte),
  .res_valid    (res_o.valid),
  .res_ready    (res_o.ready),
  .res_complete (res_o.complete),
  .res_kind     (res_o.prompt_kind)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench of the code completeness scanner
// Feeds script buffers byte by byte through the request channel. A
// behavioural model in this file predicts the results not typed into the
// directed table, and each received result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cc_pkg::*;

  localparam int          HistLen   = MAX_TAG_DEF + 2;
  localparam int unsigned DepthMax  = (1 << DEPTH_BITS_DEF) - 1;
  localparam int          RandBytes = 1750;
  localparam int          CycLimit  = 2_000_000;
  // Drain of the lookahead window plus the output register, with margin.
  localparam int          Settle    = 10;

  typedef struct {
    logic         complete;
    prompt_kind_e kind;
  } scan_res_t;

  // One row of the directed table. Only rows that end a buffer can carry a
  // typed-in result; the rest leave the prediction to the model below.
  typedef struct {
    logic [7:0]   code;
    logic         last;
    logic         typed;
    logic         complete;
    prompt_kind_e kind;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_SHORT_OPEN;
  logic cfg_data = 1'b0;

  cc_req_if req ();
  cc_res_if res ();

  code_completeness_scanner dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req),
    .res_o     (res),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.code_byte = 8'h00;
    req.last_byte = 1'b0;
    res.ready = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural model of the scanner: its own copy of the scan state and of
  // the two tag options.
  // --------------------------------------------------------------------------
  logic         opt_short, opt_asp;
  scan_mode_e   mode;
  logic         stmt_done, stmt_done_saved;
  int unsigned  curly, paren;
  logic [7:0]   recent [HistLen];
  int           rec_next, rec_count;
  logic [7:0]   tag_buf [MAX_TAG_DEF];
  int           tag_len, tag_wr;
  logic         tag_too_long;
  logic [7:0]   held [2];
  int           held_cnt;

  function automatic void scan_clear();
    mode = MODE_BODY;
    stmt_done = 1'b1;
    stmt_done_saved = 1'b0;
    curly = 0;
    paren = 0;
    foreach (recent[i]) recent[i] = 8'h00;
    rec_next = 0;
    rec_count = 0;
    foreach (tag_buf[i]) tag_buf[i] = 8'h00;
    tag_len = 0;
    tag_wr = 0;
    tag_too_long = 1'b0;
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_cnt = 0;
  endfunction

  function automatic void remember(logic [7:0] c);
    recent[rec_next] = c;
    rec_next = (rec_next + 1) % HistLen;
    if (rec_count < HistLen) rec_count++;
  endfunction

  // Is the byte k places back there, and equal to v? Bytes before the start
  // of the buffer do not exist and never match.
  function automatic logic back_is(int k, logic [7:0] v);
    if (k < 1 || k > rec_count) return 1'b0;
    return recent[(rec_next + HistLen - k) % HistLen] == v;
  endfunction

  function automatic logic tag_seen(int start);
    logic [7:0] b;
    for (int j = 0; j < tag_len && j < MAX_TAG_DEF; j++) begin
      if (start - j < 1 || start - j > rec_count) return 1'b0;
      b = recent[(rec_next + HistLen - (start - j)) % HistLen];
      if (b != tag_buf[j]) return 1'b0;
      if (b == CH_NUL) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void tag_keep(logic [7:0] c);
    if (tag_wr < MAX_TAG_DEF) tag_buf[tag_wr] = c;
    if (tag_wr <= MAX_TAG_DEF) tag_wr++;
  endfunction

  // Decides byte c with the given lookahead; returns the lookahead bytes
  // it swallows.
  function automatic int decide_byte(logic [7:0] c, int ahead, logic [7:0] a1,
                                     logic [7:0] a2);
    int len;
    len = tag_len;
    case (mode)
      MODE_SQ: begin
        if (c == CH_BSLASH) mode = MODE_SQ_ESC;
        else if (c == CH_SQUOTE) mode = MODE_BODY;
        return 0;
      end
      MODE_SQ_ESC: begin
        mode = MODE_SQ;
        return 0;
      end
      MODE_DQ: begin
        if (c == CH_BSLASH) mode = MODE_DQ_ESC;
        else if (c == CH_DQUOTE) mode = MODE_BODY;
        return 0;
      end
      MODE_DQ_ESC: begin
        mode = MODE_DQ;
        return 0;
      end
      MODE_LINE_CMT: begin
        if (c == CH_LF) mode = MODE_BODY;
        return 0;
      end
      MODE_BLOCK_CMT: begin
        if (c == CH_SLASH && back_is(1, CH_STAR)) begin
          mode = MODE_BODY;
          stmt_done = stmt_done_saved;
        end
        return 0;
      end
      MODE_DOC_OPEN: begin
        if (c == CH_CR || c == CH_LF) begin
          mode = MODE_DOC_BODY;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          if (tag_len > 0) tag_keep(c);
        end else begin
          if (tag_len == 0) tag_wr = 0;
          tag_keep(c);
          if (tag_len < MAX_TAG_DEF) tag_len++;
          else tag_too_long = 1'b1;
        end
        return 0;
      end
      MODE_DOC_BODY: begin
        if (tag_too_long || c != CH_LF) return 0;
        if (back_is(len + 1, CH_LF) && tag_seen(len)) begin
          mode = MODE_BODY;
        end else if (back_is(len + 2, CH_LF) && tag_seen(len + 1) &&
                     back_is(1, CH_SEMI)) begin
          mode = MODE_BODY;
          stmt_done = 1'b1;
        end
        return 0;
      end
      MODE_OUTSIDE: begin
        if ((opt_short && c == CH_QUEST && back_is(1, CH_LT)) ||
            (opt_asp && c == CH_PCT && back_is(1, CH_LT)) ||
            (c == CH_P && back_is(4, CH_LT) && back_is(3, CH_QUEST) &&
             back_is(2, CH_P) && back_is(1, CH_H)))
          mode = MODE_BODY;
        return 0;
      end
      default: ;
    endcase
    mode = MODE_BODY;
    case (c)
      CH_LCURLY: begin
        if (curly < DepthMax) curly++;
        stmt_done = 1'b0;
      end
      CH_RCURLY: begin
        if (curly > 0) curly--;
        stmt_done = (curly == 0);
      end
      CH_LPAREN: begin
        if (paren < DepthMax) paren++;
        stmt_done = 1'b0;
      end
      CH_RPAREN: begin
        if (paren > 0) paren--;
        stmt_done = 1'b0;
      end
      CH_SEMI: stmt_done = (paren == 0 && curly == 0);
      CH_SPACE, CH_CR, CH_LF, CH_TAB: ;
      CH_SQUOTE: mode = MODE_SQ;
      CH_DQUOTE: mode = MODE_DQ;
      CH_HASH: mode = MODE_LINE_CMT;
      CH_SLASH: begin
        if (ahead >= 1 && a1 == CH_SLASH) begin
          mode = MODE_LINE_CMT;
          return 1;
        end
        if (ahead >= 1 && a1 == CH_STAR) begin
          stmt_done_saved = stmt_done;
          stmt_done = 1'b0;
          mode = MODE_BLOCK_CMT;
          return 1;
        end
        stmt_done = 1'b0;
      end
      CH_PCT, CH_QUEST: begin
        if (c == CH_PCT && !opt_asp) begin
          stmt_done = 1'b0;
          return 0;
        end
        if (ahead >= 1 && a1 == CH_GT) begin
          mode = MODE_OUTSIDE;
          return 1;
        end
        stmt_done = 1'b0;
      end
      CH_LT: begin
        stmt_done = 1'b0;
        if (ahead >= 2 && a1 == CH_LT && a2 == CH_LT) begin
          mode = MODE_DOC_OPEN;
          tag_len = 0;
          tag_wr = 0;
          tag_too_long = 1'b0;
          return 2;
        end
      end
      default: stmt_done = 1'b0;
    endcase
    return 0;
  endfunction

  // Decides the oldest byte of the window and drops what it used up.
  function automatic int window_step(ref logic [7:0] w [3], input int n);
    int drop;
    drop = 1 + decide_byte(w[0], (n > 3) ? 2 : n - 1, w[1], w[2]);
    if (drop > n) drop = n;
    for (int j = 0; j < drop; j++) remember(w[j]);
    for (int j = drop; j < n; j++) w[j - drop] = w[j];
    return n - drop;
  endfunction

  // Takes one accepted byte; returns 1 with the scan result on a last byte.
  function automatic logic scan_byte(logic [7:0] c, logic last, output scan_res_t r);
    logic [7:0] w [3];
    int n;
    w = '{8'h00, 8'h00, 8'h00};
    n = 0;
    for (int j = 0; j < held_cnt; j++) w[n++] = held[j];
    w[n++] = c;
    r.complete = 1'b0;
    r.kind = PROMPT_NORMAL;
    if (!last) begin
      if (n == 3) n = window_step(w, n);
      for (int j = 0; j < n && j < 2; j++) held[j] = w[j];
      held_cnt = n;
      return 1'b0;
    end
    while (n > 0) n = window_step(w, n);
    case (mode)
      MODE_SQ, MODE_SQ_ESC: r.kind = PROMPT_SQUOTE;
      MODE_DQ, MODE_DQ_ESC: r.kind = PROMPT_DQUOTE;
      MODE_BLOCK_CMT:       r.kind = PROMPT_COMMENT;
      MODE_DOC_BODY:        r.kind = PROMPT_HEREDOC;
      MODE_OUTSIDE:         r.kind = PROMPT_OUTSIDE;
      default: r.kind = (paren != 0) ? PROMPT_PAREN :
                        (curly != 0) ? PROMPT_CURLY : PROMPT_NORMAL;
    endcase
    r.complete = stmt_done && (curly == 0);
    scan_clear();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors. Both channels are sampled at the falling edge: the handshake
  // seen there is the one that completes at the next rising edge, and
  // nothing the testbench drives changes in between.
  // --------------------------------------------------------------------------
  scan_res_t results_due [$];
  logic      use_typed = 1'b0;
  scan_res_t typed_res;
  int        n_fail = 0;
  int        n_bytes = 0;
  int        n_results = 0;
  int        tx_idle = 0;
  int        rx_idle = 0;

  always @(negedge clk) begin : req_monitor
    scan_res_t r;
    if (rst_n && req.valid && req.ready) begin
      n_bytes++;
      if (scan_byte(req.code_byte, req.last_byte, r))
        results_due.push_back(use_typed ? typed_res : r);
    end
  end

  always @(negedge clk) begin : res_monitor
    scan_res_t want;
    if (rst_n && res.valid && res.ready) begin
      n_results++;
      if (results_due.size() == 0) begin
        $error("result with no request waiting: complete %0d, prompt %0d",
               res.complete, res.prompt_kind);
        n_fail++;
      end else begin
        want = results_due.pop_front();
        if (res.complete !== want.complete) begin
          $error("complete: expected %0d, got %0d", want.complete, res.complete);
          n_fail++;
        end
        if (res.prompt_kind !== want.kind) begin
          $error("prompt_kind: expected %0d, got %0d", want.kind, res.prompt_kind);
          n_fail++;
        end
      end
    end
  end

  // The result side stalls at random by the current share.
  always @(posedge clk) begin
    res.ready <= ($urandom_range(99) >= rx_idle);
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks. Each is entered just after a rising edge.
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] c, logic last);
    while ($urandom_range(99) < tx_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.code_byte <= c;
    req.last_byte <= last;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
  endtask

  task automatic send_buffer(ref logic [7:0] buf_q [$]);
    for (int i = 0; i < buf_q.size(); i++)
      send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  // Options change only once every pending result is in and the drain of
  // the last buffer is surely over.
  task automatic set_options(logic short_en, logic pct_en);
    req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SHORT_OPEN;
    cfg_data <= short_en;
    @(posedge clk);
    cfg_idx <= CFG_PCT_TAGS;
    cfg_data <= pct_en;
    @(posedge clk);
    cfg_we <= 1'b0;
    opt_short = short_en;
    opt_asp = pct_en;
  endtask

  function automatic void add_str(ref logic [7:0] q [$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  // A heredoc: opener, optional blanks, a tag of random letters, an optional
  // body line and mostly a closing line, with or without the semicolon. Now
  // and then the tag is close to or past the longest one the store holds.
  function automatic void add_heredoc(ref logic [7:0] q [$]);
    logic [7:0] tag [$];
    int len;
    len = ($urandom_range(15) == 0) ? $urandom_range(MAX_TAG_DEF - 2, MAX_TAG_DEF + 2)
                                    : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) tag.push_back(8'(8'h41 + $urandom_range(3)));
    add_str(q, "<<<");
    if ($urandom_range(1)) q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    foreach (tag[i]) q.push_back(tag[i]);
    if ($urandom_range(3) == 0) q.push_back(CH_SPACE);
    q.push_back($urandom_range(3) == 0 ? CH_CR : CH_LF);
    if ($urandom_range(1)) add_str(q, "x{\n");
    if ($urandom_range(4) != 0) begin
      // A wrong tag now and then keeps the body open.
      if ($urandom_range(5) == 0) tag[0] = 8'h5A;
      foreach (tag[i]) q.push_back(tag[i]);
      if ($urandom_range(1)) q.push_back(CH_SEMI);
      q.push_back(CH_LF);
    end
  endfunction

  // Builds one buffer from script fragments, with raw bytes as noise.
  function automatic void make_buffer(ref logic [7:0] q [$]);
    int pieces;
    q.delete();
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(24))
        0:  add_str(q, "{");
        1:  add_str(q, "}");
        2:  add_str(q, "(");
        3:  add_str(q, ")");
        4:  add_str(q, ";");
        5:  add_str(q, "'a\\'");
        6:  add_str(q, "\"b\\\"");
        7:  add_str(q, "'");
        8:  add_str(q, "\"");
        9:  add_str(q, "# c\n");
        10: add_str(q, "//");
        11: add_str(q, "/*");
        12: add_str(q, "*/");
        13: add_str(q, "?>");
        14: add_str(q, "%>");
        15: add_str(q, "<?php");
        16: add_str(q, "<?");
        17: add_str(q, "<%");
        18: add_heredoc(q);
        19: add_str(q, "\n");
        20: add_str(q, " ");
        21: add_str(q, "x=1;");
        22: add_str(q, "/*/");
        default: q.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: single-byte and short buffers with openers, openers cut
  // short and the extremes of the byte, in mixed order.
  // --------------------------------------------------------------------------
  row_t rows [] = '{
    '{CH_SEMI,   1'b1, 1'b1, 1'b1, PROMPT_NORMAL},
    '{CH_LCURLY, 1'b1, 1'b1, 1'b0, PROMPT_CURLY},
    '{CH_LPAREN, 1'b1, 1'b1, 1'b0, PROMPT_PAREN},
    '{CH_SQUOTE, 1'b1, 1'b1, 1'b1, PROMPT_SQUOTE},
    '{CH_DQUOTE, 1'b1, 1'b1, 1'b1, PROMPT_DQUOTE},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_STAR,   1'b1, 1'b1, 1'b0, PROMPT_COMMENT},
    '{CH_QUEST,  1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_GT,     1'b1, 1'b1, 1'b1, PROMPT_OUTSIDE},
    '{CH_LT,     1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_LT,     1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_LT,     1'b1, 1'b1, 1'b0, PROMPT_NORMAL},
    '{CH_SLASH,  1'b1, 1'b1, 1'b0, PROMPT_NORMAL},
    '{8'hFF,     1'b1, 1'b1, 1'b0, PROMPT_NORMAL},
    '{CH_NUL,    1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_RCURLY, 1'b1, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_HASH,   1'b1, 1'b1, 1'b1, PROMPT_NORMAL},
    '{CH_QUEST,  1'b1, 1'b1, 1'b0, PROMPT_NORMAL},
    '{CH_PCT,    1'b0, 1'b0, 1'b0, PROMPT_NORMAL},
    '{CH_GT,     1'b1, 1'b0, 1'b0, PROMPT_NORMAL}
  };

  initial begin : stimulus
    logic [7:0] buf_q [$];
    int sent;
    opt_short = 1'b0;
    opt_asp = 1'b0;
    scan_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with reset options and no idling on either side.
    foreach (rows[i]) begin
      use_typed <= rows[i].typed;
      typed_res.complete = rows[i].complete;
      typed_res.kind = rows[i].kind;
      send_byte(rows[i].code, rows[i].last);
    end
    use_typed <= 1'b0;

    // Random part: six phases over every option setting, with the idling
    // shares swapped after the second phase and dropped in the last two.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      set_options(ph[0], ph[1] ^ (ph >= 4));
      tx_idle = (ph < 2) ? 29 : (ph < 4) ? 54 : 0;
      rx_idle = (ph < 2) ? 54 : (ph < 4) ? 29 : 0;
      while (sent < RandBytes * (ph + 1) / 6) begin
        make_buffer(buf_q);
        send_buffer(buf_q);
        sent += buf_q.size();
      end
    end
    req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);

    $display("Scanned %0d bytes and checked %0d results over all tag option settings,",
             n_bytes, n_results);
    $display("including cut-short openers, heredocs and tags past the store size.");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- code_completeness_scanner.f -----
rtl/cc_pkg.sv
rtl/cc_if.sv
rtl/cc_hist_cell.sv
rtl/cc_tag_cell.sv
rtl/code_completeness_scanner.sv
rtl/cc_checker.sv
sim/tb_top.sv
